>>> src/tcfws_pkg.sv
// ----------------------------------------------------------------------------
// tcfws_pkg
// Shared types and constants of the two-class FIFO weighted server.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfws_pkg;

  // Field widths of one entry and of the result counts
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int COUNT_W  = 5;
  localparam int BURST_W  = 4;

  // Defaults
  localparam int                 QUEUE_DEPTH_DEF = 16;
  localparam logic [BURST_W-1:0] BURST_RESET     = 4'd3;

  // Action code of a request
  localparam logic ACT_SERVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // One stored queue entry
  typedef struct packed {
    logic                company;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } entry_t;

endpackage

`default_nettype wire

>>> src/two_class_fifo_weighted_server_core.sv
// ----------------------------------------------------------------------------
// two_class_fifo_weighted_server_core
// Two bounded FIFOs (priority and normal) with a weighted serve rule.
// ----------------------------------------------------------------------------
// One request is taken every cycle unless in_stall holds it off, and each
// request gives exactly one result. It passes the input register, where the
// decision and the head/tail/count updates happen, and then the result
// register, loaded together with the synchronous read of the FIFO memory. This
// rate holds while results are taken and is set by the single decision stage
// that touches only one FIFO port and the small counters. An enqueue to a full
// FIFO is dropped with status full; a serve with both FIFOs empty changes
// nothing. Priority entries are served while fewer than burst_limit have been
// served in a row (or whenever the normal FIFO is empty); serving a normal
// entry clears the run count. burst_limit may only be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_fifo_weighted_server_core #(
  parameter int QUEUE_DEPTH = tcfws_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  // configuration write channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [tcfws_pkg::BURST_W-1:0]      cfg_data,
  // request channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                action,
  input  wire                                is_priority,
  input  wire                                is_company,
  input  wire  [tcfws_pkg::HOUR_W-1:0]       arrival_hour,
  input  wire  [tcfws_pkg::MINUTE_W-1:0]     arrival_minute,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [1:0]                         status,
  output logic                               served_priority,
  output logic                               served_company,
  output logic [tcfws_pkg::HOUR_W-1:0]       served_hour,
  output logic [tcfws_pkg::MINUTE_W-1:0]     served_minute,
  output logic [tcfws_pkg::COUNT_W-1:0]      normal_count,
  output logic [tcfws_pkg::COUNT_W-1:0]      priority_count
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Input register
  logic                  s1_valid;
  logic                  s1_action;
  logic                  s1_is_priority;
  tcfws_pkg::entry_t     s1_entry;

  // FIFO state
  logic [PTR_W-1:0]      n_head, n_tail, p_head, p_tail;
  logic [PTR_W-1:0]      n_head_next, n_tail_next, p_head_next, p_tail_next;
  logic [CNT_W-1:0]      n_count, p_count, n_count_next, p_count_next;
  logic [tcfws_pkg::BURST_W-1:0] burst_count, burst_count_next, burst_limit;

  // FIFO memories and their read registers
  tcfws_pkg::entry_t     n_mem [QUEUE_DEPTH];
  tcfws_pkg::entry_t     p_mem [QUEUE_DEPTH];
  tcfws_pkg::entry_t     n_rdata, p_rdata;

  // Result register
  tcfws_pkg::status_t    res_status;
  logic                  res_from_prio;
  logic [CNT_W-1:0]      res_n_count, res_p_count;

  // Decision signals
  logic                  out_load, s1_fire, in_take;
  logic                  is_serve, n_empty, p_empty, n_full, p_full, below_limit;
  logic                  push_n, push_p, take_n, take_p, serve_any;
  tcfws_pkg::status_t    status_next;
  tcfws_pkg::entry_t     served_entry;

  // Handshake: result register frees when empty or taken
  assign out_load  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_load;
  assign in_stall  = s1_valid && !out_load;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Decide what the request in the input register does
  always_comb begin
    is_serve    = (s1_action == tcfws_pkg::ACT_SERVE);
    n_empty     = (n_count == '0);
    p_empty     = (p_count == '0);
    n_full      = (n_count == CNT_FULL);
    p_full      = (p_count == CNT_FULL);
    below_limit = (burst_count < burst_limit);
    push_p      = !is_serve && s1_is_priority && !p_full;
    push_n      = !is_serve && !s1_is_priority && !n_full;
    serve_any   = is_serve && !(n_empty && p_empty);
    take_p      = serve_any && ((below_limit && !p_empty) || n_empty);
    take_n      = serve_any && !take_p;
    if (!is_serve) begin
      status_next = (push_p || push_n) ? tcfws_pkg::ST_ENQUEUED : tcfws_pkg::ST_FULL;
    end else begin
      status_next = serve_any ? tcfws_pkg::ST_SERVED : tcfws_pkg::ST_EMPTY;
    end
  end

  // Advance pointers, counts and the run count
  always_comb begin
    n_head_next      = n_head;
    n_tail_next      = n_tail;
    n_count_next     = n_count;
    p_head_next      = p_head;
    p_tail_next      = p_tail;
    p_count_next     = p_count;
    burst_count_next = burst_count;
    if (push_n) begin
      n_tail_next  = (n_tail == PTR_LAST) ? '0 : n_tail + 1'b1;
      n_count_next = n_count + 1'b1;
    end
    if (push_p) begin
      p_tail_next  = (p_tail == PTR_LAST) ? '0 : p_tail + 1'b1;
      p_count_next = p_count + 1'b1;
    end
    if (take_n) begin
      n_head_next      = (n_head == PTR_LAST) ? '0 : n_head + 1'b1;
      n_count_next     = n_count - 1'b1;
      burst_count_next = '0;
    end
    if (take_p) begin
      p_head_next  = (p_head == PTR_LAST) ? '0 : p_head + 1'b1;
      p_count_next = p_count - 1'b1;
      if (below_limit) begin
        burst_count_next = burst_count + 1'b1;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_limit <= tcfws_pkg::BURST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      burst_limit <= cfg_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      n_head      <= '0;
      n_tail      <= '0;
      n_count     <= '0;
      p_head      <= '0;
      p_tail      <= '0;
      p_count     <= '0;
      burst_count <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        n_head      <= n_head_next;
        n_tail      <= n_tail_next;
        n_count     <= n_count_next;
        p_head      <= p_head_next;
        p_tail      <= p_tail_next;
        p_count     <= p_count_next;
        burst_count <= burst_count_next;
      end
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action        <= action;
      s1_is_priority   <= is_priority;
      s1_entry.company <= is_company;
      s1_entry.hour    <= arrival_hour;
      s1_entry.minute  <= arrival_minute;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_status    <= status_next;
      res_from_prio <= take_p;
      res_n_count   <= n_count_next;
      res_p_count   <= p_count_next;
    end
  end

  // Normal FIFO memory
  always_ff @(posedge clk) begin
    if (s1_fire && push_n) begin
      n_mem[n_tail] <= s1_entry;
    end
    if (s1_fire && take_n) begin
      n_rdata <= n_mem[n_head];
    end
  end

  // Priority FIFO memory
  always_ff @(posedge clk) begin
    if (s1_fire && push_p) begin
      p_mem[p_tail] <= s1_entry;
    end
    if (s1_fire && take_p) begin
      p_rdata <= p_mem[p_head];
    end
  end

  // Drive the result fields; zero the entry unless something was served
  always_comb begin
    served_entry = res_from_prio ? p_rdata : n_rdata;
    if (res_status != tcfws_pkg::ST_SERVED) begin
      served_entry = '0;
    end
  end

  assign status          = res_status;
  assign served_priority = res_from_prio;
  assign served_company  = served_entry.company;
  assign served_hour     = served_entry.hour;
  assign served_minute   = served_entry.minute;
  assign normal_count    = tcfws_pkg::COUNT_W'(res_n_count);
  assign priority_count  = tcfws_pkg::COUNT_W'(res_p_count);

endmodule

`default_nettype wire

>>> src/tcfws_checker.sv
// ----------------------------------------------------------------------------
// tcfws_checker
// Port-level assertions for the two-class FIFO weighted server.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfws_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire [1:0]                         status,
  input wire                               served_priority,
  input wire                               served_company,
  input wire [tcfws_pkg::HOUR_W-1:0]       served_hour,
  input wire [tcfws_pkg::MINUTE_W-1:0]     served_minute,
  input wire [tcfws_pkg::COUNT_W-1:0]      normal_count,
  input wire [tcfws_pkg::COUNT_W-1:0]      priority_count
);

  // Reset empties the result stage
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A result that served nothing carries zero entry fields
  a_unserved_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != tcfws_pkg::ST_SERVED) |->
      !served_priority && !served_company && served_hour == '0 && served_minute == '0)
    else $error("entry fields set on a result that served nothing");

  // Empty status means both FIFOs report no entries
  a_empty_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tcfws_pkg::ST_EMPTY) |->
      normal_count == '0 && priority_count == '0)
    else $error("empty status with entries still queued");

endmodule

bind two_class_fifo_weighted_server_core tcfws_checker u_tcfws_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .served_priority(served_priority),
  .served_company (served_company),
  .served_hour    (served_hour),
  .served_minute  (served_minute),
  .normal_count   (normal_count),
  .priority_count (priority_count)
);

`default_nettype wire
